@@ rtl/nsag_pkg.sv @@
`default_nettype none

package nsag_pkg;

    localparam int IDX_BITS  = 32;
    localparam int CFG_BITS  = 64;
    localparam int RANK_BITS = 3;
    localparam int CIDX_BITS = 2;

    localparam logic [CIDX_BITS-1:0] CFG_RANK      = 2'd0;
    localparam logic [CIDX_BITS-1:0] CFG_IN_SHAPE  = 2'd1;
    localparam logic [CIDX_BITS-1:0] CFG_OUT_SHAPE = 2'd2;
    localparam logic [CIDX_BITS-1:0] CFG_BEGIN     = 2'd3;

    localparam logic [CFG_BITS-1:0] SHAPE_RESET = 64'h0001_0001_0001_0001;

    typedef logic [IDX_BITS-1:0] idx_t;

    // bits of a 32-bit index that survive truncation to addr_bits
    function automatic idx_t addr_mask(input int addr_bits);
        idx_t m;
        m = '0;
        for (int i = 0; i < IDX_BITS; i++)
        begin
            m[i] = (i < addr_bits);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

@@ rtl/nsag_mac_stage.sv @@
`default_nettype none

module nsag_mac_stage #(
    parameter int MAX_DIMS  = 4,
    parameter int DIM_BITS  = 16,
    parameter int ADDR_BITS = 32,
    parameter int DIM       = 0
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           up_valid,
    output logic                          up_ready,
    input  wire  [MAX_DIMS*DIM_BITS-1:0]  up_coord,
    input  wire  [nsag_pkg::IDX_BITS-1:0] up_dest,
    input  wire                           up_last,
    input  wire  [ADDR_BITS-1:0]          up_acc,
    input  wire  [ADDR_BITS-1:0]          up_stride,
    input  wire                           dim_used,
    input  wire  [DIM_BITS-1:0]           dim_begin,
    input  wire  [DIM_BITS-1:0]           dim_in_ext,
    output logic                          dn_valid,
    input  wire                           dn_ready,
    output logic [MAX_DIMS*DIM_BITS-1:0]  dn_coord,
    output logic [nsag_pkg::IDX_BITS-1:0] dn_dest,
    output logic                          dn_last,
    output logic [ADDR_BITS-1:0]          dn_acc,
    output logic [ADDR_BITS-1:0]          dn_stride
);
    import nsag_pkg::*;

    localparam int TERM_BITS  = DIM_BITS + 1;
    localparam int PROD_BITS  = TERM_BITS + ADDR_BITS;
    localparam int SPROD_BITS = ADDR_BITS + DIM_BITS;

    logic                          valid_reg;
    logic                          valid_next;
    logic [MAX_DIMS*DIM_BITS-1:0]  coord_reg;
    logic [IDX_BITS-1:0]           dest_reg;
    logic                          last_reg;
    logic [ADDR_BITS-1:0]          acc_reg;
    logic [ADDR_BITS-1:0]          stride_reg;
    logic [ADDR_BITS-1:0]          acc_next;
    logic [ADDR_BITS-1:0]          stride_next;
    logic [TERM_BITS-1:0]          term;
    logic [PROD_BITS-1:0]          prod;
    logic [SPROD_BITS-1:0]         sprod;
    logic                          load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    // (coordinate + offset) * stride, stride is multiplied by this dim's input extent
    assign term  = {1'b0, up_coord[DIM*DIM_BITS +: DIM_BITS]} + {1'b0, dim_begin};
    assign prod  = PROD_BITS'(term) * PROD_BITS'(up_stride);
    assign sprod = SPROD_BITS'(up_stride) * SPROD_BITS'(dim_in_ext);

    assign acc_next    = dim_used ? up_acc + prod[ADDR_BITS-1:0] : up_acc;
    assign stride_next = dim_used ? sprod[ADDR_BITS-1:0] : up_stride;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (dn_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            coord_reg  <= up_coord;
            dest_reg   <= up_dest;
            last_reg   <= up_last;
            acc_reg    <= acc_next;
            stride_reg <= stride_next;
        end
    end

    assign dn_valid  = valid_reg;
    assign dn_coord  = coord_reg;
    assign dn_dest   = dest_reg;
    assign dn_last   = last_reg;
    assign dn_acc    = acc_reg;
    assign dn_stride = stride_reg;

endmodule

`default_nettype wire

@@ rtl/nd_slice_address_generator.sv @@
`default_nettype none

// N-dimensional slice address generator. Each accepted request (tdata bit 0 =
// restart) yields one result: source index (tdata[31:0]), destination index
// (tdata[63:32]) and tlast on the final element of the slice, walking the
// slice in row-major order and wrapping after tlast. With an empty slice a
// request yields nothing. A new request is taken every cycle unless the result
// side stalls; each result is registered through the index pipeline: a snapshot
// register and one multiply-accumulate stage per dimension. Configuration
// writes are accepted at any time but belong in idle periods.
module nd_slice_address_generator #(
    parameter int MAX_DIMS  = 4,
    parameter int DIM_BITS  = 16,
    parameter int ADDR_BITS = 32
) (
    input  wire                            clk,
    input  wire                            rst_n,
    // configuration
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire  [nsag_pkg::CIDX_BITS-1:0] cfg_index,
    input  wire  [nsag_pkg::CFG_BITS-1:0]  cfg_data,
    // requests
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire  [7:0]                     s_tdata,   // [0] restart
    // results
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [63:0]                    m_tdata,   // [31:0] source_index, [63:32] dest_index
    output logic                           m_tlast    // last
);
    import nsag_pkg::*;

    localparam int NST = MAX_DIMS + 1;
    localparam int CW  = MAX_DIMS * DIM_BITS;
    localparam idx_t DEST_MASK = addr_mask(ADDR_BITS);

    logic [RANK_BITS-1:0] rank_reg;
    logic [CFG_BITS-1:0]  in_shape_reg;
    logic [CFG_BITS-1:0]  out_shape_reg;
    logic [CFG_BITS-1:0]  begin_reg;

    logic [MAX_DIMS-1:0][DIM_BITS-1:0] in_ext;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0] out_ext;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0] beg_off;
    logic [MAX_DIMS-1:0]               used;

    logic [MAX_DIMS-1:0][DIM_BITS-1:0] coord_reg;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0] coord_next;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0] coord_cur;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0] coord_step;
    logic [MAX_DIMS-1:0]               at_end;
    idx_t                              dest_reg;
    idx_t                              dest_next;
    idx_t                              dest_cur;
    logic                              restart;
    logic                              accept;
    logic                              empty;
    logic                              last;
    logic                              carry;

    logic                              st0_valid_reg;
    logic                              st0_valid_next;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0] st0_coord_reg;
    idx_t                              st0_dest_reg;
    logic                              st0_last_reg;
    logic                              st0_load;

    logic                 ch_valid  [NST];
    logic                 ch_ready  [NST];
    logic [CW-1:0]        ch_coord  [NST];
    idx_t                 ch_dest   [NST];
    logic                 ch_last   [NST];
    logic [ADDR_BITS-1:0] ch_acc    [NST];
    logic [ADDR_BITS-1:0] ch_stride [NST];

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg      <= RANK_BITS'(1);
            in_shape_reg  <= SHAPE_RESET;
            out_shape_reg <= SHAPE_RESET;
            begin_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RANK:      rank_reg      <= cfg_data[RANK_BITS-1:0];
                CFG_IN_SHAPE:  in_shape_reg  <= cfg_data;
                CFG_OUT_SHAPE: out_shape_reg <= cfg_data;
                CFG_BEGIN:     begin_reg     <= cfg_data;
                default:       rank_reg      <= rank_reg;
            endcase
        end
    end

    // per-dimension fields; a field starting past bit 63 reads zero
    for (genvar d = 0; d < MAX_DIMS; d++)
    begin : g_field
        localparam int SH = d * DIM_BITS;
        logic [CFG_BITS-1:0] in_sh;
        logic [CFG_BITS-1:0] out_sh;
        logic [CFG_BITS-1:0] beg_sh;

        if (SH < CFG_BITS)
        begin : g_in
            assign in_sh  = in_shape_reg  >> SH;
            assign out_sh = out_shape_reg >> SH;
            assign beg_sh = begin_reg     >> SH;
        end
        else
        begin : g_out
            assign in_sh  = '0;
            assign out_sh = '0;
            assign beg_sh = '0;
        end

        assign in_ext[d]  = in_sh[DIM_BITS-1:0];
        assign out_ext[d] = out_sh[DIM_BITS-1:0];
        assign beg_off[d] = beg_sh[DIM_BITS-1:0];
        assign used[d]    = int'(rank_reg) > d;
    end

    // coordinate walk
    assign restart  = s_tdata[0];
    assign accept   = s_tvalid && s_tready;
    assign dest_cur = restart ? '0 : dest_reg;

    always_comb
    begin
        coord_cur = restart ? '0 : coord_reg;
        empty     = 1'b0;
        last      = 1'b1;
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            at_end[i] = coord_cur[i] >= (out_ext[i] - DIM_BITS'(1));
            if (used[i])
            begin
                if (out_ext[i] == '0)
                begin
                    empty = 1'b1;
                end
                if (!at_end[i])
                begin
                    last = 1'b0;
                end
            end
        end

        // innermost first; unused dims pass the carry on untouched
        carry = 1'b1;
        for (int i = MAX_DIMS - 1; i >= 0; i--)
        begin
            coord_step[i] = coord_cur[i];
            if (used[i] && carry)
            begin
                if (at_end[i])
                begin
                    coord_step[i] = '0;
                end
                else
                begin
                    coord_step[i] = coord_cur[i] + DIM_BITS'(1);
                    carry         = 1'b0;
                end
            end
        end

        coord_next = coord_reg;
        dest_next  = dest_reg;
        if (accept)
        begin
            if (empty)
            begin
                coord_next = coord_cur;
                dest_next  = dest_cur;
            end
            else if (last)
            begin
                coord_next = '0;
                dest_next  = '0;
            end
            else
            begin
                coord_next = coord_step;
                dest_next  = dest_cur + IDX_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_reg <= '0;
            dest_reg  <= '0;
        end
        else
        begin
            coord_reg <= coord_next;
            dest_reg  <= dest_next;
        end
    end

    // stage 0: snapshot of the element
    assign st0_load = accept && !empty;
    assign s_tready = !st0_valid_reg || ch_ready[0];

    always_comb
    begin
        st0_valid_next = st0_valid_reg;
        if (st0_load)
        begin
            st0_valid_next = 1'b1;
        end
        else if (ch_ready[0])
        begin
            st0_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st0_valid_reg <= 1'b0;
        end
        else
        begin
            st0_valid_reg <= st0_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st0_load)
        begin
            st0_coord_reg <= coord_cur;
            st0_dest_reg  <= dest_cur & DEST_MASK;
            st0_last_reg  <= last;
        end
    end

    assign ch_valid[0]  = st0_valid_reg;
    assign ch_coord[0]  = st0_coord_reg;
    assign ch_dest[0]   = st0_dest_reg;
    assign ch_last[0]   = st0_last_reg;
    assign ch_acc[0]    = '0;
    assign ch_stride[0] = ADDR_BITS'(1);

    // one multiply-accumulate stage per dimension, innermost first
    for (genvar k = 1; k < NST; k++)
    begin : g_stage
        localparam int D = MAX_DIMS - k;

        nsag_mac_stage #(
            .MAX_DIMS  (MAX_DIMS),
            .DIM_BITS  (DIM_BITS),
            .ADDR_BITS (ADDR_BITS),
            .DIM       (D)
        ) u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (ch_valid[k-1]),
            .up_ready   (ch_ready[k-1]),
            .up_coord   (ch_coord[k-1]),
            .up_dest    (ch_dest[k-1]),
            .up_last    (ch_last[k-1]),
            .up_acc     (ch_acc[k-1]),
            .up_stride  (ch_stride[k-1]),
            .dim_used   (used[D]),
            .dim_begin  (beg_off[D]),
            .dim_in_ext (in_ext[D]),
            .dn_valid   (ch_valid[k]),
            .dn_ready   (ch_ready[k]),
            .dn_coord   (ch_coord[k]),
            .dn_dest    (ch_dest[k]),
            .dn_last    (ch_last[k]),
            .dn_acc     (ch_acc[k]),
            .dn_stride  (ch_stride[k])
        );
    end

    assign ch_ready[NST-1] = m_tready;
    assign m_tvalid        = ch_valid[NST-1];
    assign m_tlast         = ch_last[NST-1];
    assign m_tdata[63:32]  = ch_dest[NST-1];

    if (ADDR_BITS >= IDX_BITS)
    begin : g_src_cut
        assign m_tdata[31:0] = ch_acc[NST-1][IDX_BITS-1:0];
    end
    else
    begin : g_src_ext
        assign m_tdata[31:0] = IDX_BITS'(ch_acc[NST-1]);
    end

endmodule

`default_nettype wire

@@ rtl/nsag_checker.sv @@
`default_nettype none

module nsag_checker #(
    parameter int MAX_DIMS  = 4,
    parameter int DIM_BITS  = 16,
    parameter int ADDR_BITS = 32
) (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            cfg_valid,
    input wire                            cfg_ready,
    input wire  [nsag_pkg::CIDX_BITS-1:0] cfg_index,
    input wire  [nsag_pkg::CFG_BITS-1:0]  cfg_data,
    input wire                            s_tvalid,
    input wire                            s_tready,
    input wire  [7:0]                     s_tdata,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire  [63:0]                    m_tdata,
    input wire                            m_tlast
);
    import nsag_pkg::*;

    localparam idx_t KEEP = addr_mask(ADDR_BITS);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge clk) $rose(rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

    // an empty or draining output side never blocks requests
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("request blocked with output side free");

    // indices stay within the address width
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[31:0] & ~KEEP) == '0) && ((m_tdata[63:32] & ~KEEP) == '0))
        else $error("index wider than the address width");

endmodule

bind nd_slice_address_generator nsag_checker #(
    .MAX_DIMS  (MAX_DIMS),
    .DIM_BITS  (DIM_BITS),
    .ADDR_BITS (ADDR_BITS)
) u_checker (.*);

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import nsag_pkg::*;

    localparam int MAX_DIMS       = 4;
    localparam int DIM_BITS       = 16;
    localparam int ADDR_BITS      = 32;
    localparam int PIPE_LAT       = MAX_DIMS + 1;
    localparam int SETTLE_CYCLES  = PIPE_LAT + 8;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int RANDOM_ITEMS   = 1030;

    typedef struct packed {
        idx_t src;
        idx_t dst;
        logic last;
    } slice_addr_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CIDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]  cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;   // [0] restart
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [63:0]          m_tdata;          // [31:0] source_index, [63:32] dest_index
    logic                 m_tlast;          // last

    // shadow of the block's registers and walk state
    logic [RANK_BITS-1:0] shadow_rank      = 3'd1;
    logic [CFG_BITS-1:0]  shadow_in_shape  = SHAPE_RESET;
    logic [CFG_BITS-1:0]  shadow_out_shape = SHAPE_RESET;
    logic [CFG_BITS-1:0]  shadow_begin     = '0;
    logic [DIM_BITS-1:0]  walk_coord [MAX_DIMS];
    idx_t                 walk_dest        = '0;

    slice_addr_t          addr_expect_q [$];
    int                   err_cnt       = 0;
    int                   rx_hold_cycles = 0;
    logic                 rx_free       = 1'b0;
    int unsigned          cycle_cnt     = 0;

    nd_slice_address_generator #(
        .MAX_DIMS  (MAX_DIMS),
        .DIM_BITS  (DIM_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
                     addr_expect_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [DIM_BITS-1:0] dim_field(input logic [CFG_BITS-1:0] pv,
                                                      input int d);
        return pv[d*DIM_BITS +: DIM_BITS];
    endfunction

    // one walk step: expected addresses for a request, if the slice is not empty
    task automatic slice_step(input logic restart);
        int                  n;
        int                  d;
        logic [63:0]         stride;
        logic [63:0]         src;
        logic                at_end;
        logic                carried;
        logic [DIM_BITS-1:0] ext;
        slice_addr_t         r;
        if (restart)
        begin
            for (d = 0; d < MAX_DIMS; d++)
                walk_coord[d] = '0;
            walk_dest = '0;
        end
        n = (shadow_rank > MAX_DIMS) ? MAX_DIMS : int'(shadow_rank);
        for (d = 0; d < n; d++)
            if (dim_field(shadow_out_shape, d) == '0)
                return;
        stride = 64'd1;
        src    = 64'd0;
        at_end = 1'b1;
        for (d = n - 1; d >= 0; d--)
        begin
            ext    = dim_field(shadow_out_shape, d);
            src    = src + ({48'd0, walk_coord[d]} + {48'd0, dim_field(shadow_begin, d)})
                     * stride;
            stride = stride * {48'd0, dim_field(shadow_in_shape, d)};
            if (walk_coord[d] < ext - 16'd1)
                at_end = 1'b0;
        end
        r.src  = src[IDX_BITS-1:0];
        r.dst  = walk_dest;
        r.last = at_end;
        addr_expect_q.push_back(r);
        if (at_end)
        begin
            for (d = 0; d < MAX_DIMS; d++)
                walk_coord[d] = '0;
            walk_dest = '0;
        end
        else
        begin
            carried = 1'b1;
            for (d = n - 1; d >= 0; d--)
            begin
                if (carried)
                begin
                    ext = dim_field(shadow_out_shape, d);
                    if (walk_coord[d] >= ext - 16'd1)
                        walk_coord[d] = '0;
                    else
                    begin
                        walk_coord[d] = walk_coord[d] + 16'd1;
                        carried = 1'b0;
                    end
                end
            end
            walk_dest = walk_dest + 1;
        end
    endtask

    task automatic report_mismatch(input string what, input idx_t got, input idx_t want);
        $display("[%0t] mismatch on %s: got %08h, want %08h", $realtime, what, got, want);
        err_cnt++;
    endtask

    always @(posedge clk)
    begin : result_monitor
        slice_addr_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RANK:      shadow_rank      = cfg_data[RANK_BITS-1:0];
                    CFG_IN_SHAPE:  shadow_in_shape  = cfg_data;
                    CFG_OUT_SHAPE: shadow_out_shape = cfg_data;
                    CFG_BEGIN:     shadow_begin     = cfg_data;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (addr_expect_q.size() == 0)
                    report_mismatch("unexpected result", m_tdata[31:0], '0);
                else
                begin
                    want = addr_expect_q.pop_front();
                    if (m_tdata[31:0] !== want.src)
                        report_mismatch("source_index", m_tdata[31:0], want.src);
                    if (m_tdata[63:32] !== want.dst)
                        report_mismatch("dest_index", m_tdata[63:32], want.dst);
                    if (m_tlast !== want.last)
                        report_mismatch("last", idx_t'(m_tlast), idx_t'(want.last));
                end
            end
            if (s_tvalid && s_tready)
                slice_step(s_tdata[0]);
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [CFG_BITS-1:0] rand_lanes(input int lo, input int hi);
        logic [CFG_BITS-1:0] v;
        int                  d;
        for (d = 0; d < 4; d++)
            v[d*DIM_BITS +: DIM_BITS] = DIM_BITS'($urandom_range(hi, lo));
        return v;
    endfunction

    // result side pacing
    initial
    begin : rx_pacing
        int run_left;
        int stall_left;
        run_left   = 0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                rx_hold_cycles--;
            end
            else if (rx_free)
                m_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (run_left > 0)
            begin
                m_tready <= 1'b1;
                run_left--;
            end
            else
            begin
                run_left   = gap_len();
                stall_left = gap_len();
                m_tready <= 1'b1;
            end
        end
    end

    task automatic cfg_write(input logic [CIDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // valid stays high on return; the caller idles or sends the next request
    task automatic send_req(input logic restart);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic idle_sender(input int n);
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // drop valid and wait for a clock edge first so the last accepted request is already queued
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (addr_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_reset_state();
        send_req(1'b0);
        idle_sender(gap_len());
        send_req(1'b1);
        wait_drained();
    endtask

    task automatic test_basic_walk();
        int k;
        cfg_write(CFG_RANK, 64'd3);
        cfg_write(CFG_IN_SHAPE, {16'd1, 16'd7, 16'd6, 16'd5});
        cfg_write(CFG_OUT_SHAPE, {16'd1, 16'd3, 16'd2, 16'd2});
        cfg_write(CFG_BEGIN, {16'd0, 16'd3, 16'd2, 16'd1});
        for (k = 0; k < 6; k++)
        begin
            send_req(1'b0);
            idle_sender(gap_len());
        end
        send_req(1'b1);
        send_req(1'b0);
        send_req(1'b0);
        wait_drained();
    endtask

    task automatic test_extremes();
        // rank saturates, every field at its top, source index wraps
        cfg_write(CFG_RANK, 64'd7);
        cfg_write(CFG_IN_SHAPE, {64{1'b1}});
        cfg_write(CFG_OUT_SHAPE, {64{1'b1}});
        cfg_write(CFG_BEGIN, {64{1'b1}});
        send_req(1'b1);
        send_req(1'b0);
        wait_drained();
        // shrink the slice mid-walk: coordinate past its extent ends the walk
        cfg_write(CFG_OUT_SHAPE, SHAPE_RESET);
        send_req(1'b0);
        wait_drained();
    endtask

    task automatic test_special_shapes();
        int k;
        // scalar
        cfg_write(CFG_RANK, 64'd0);
        cfg_write(CFG_OUT_SHAPE, 64'd0);
        send_req(1'b0);
        send_req(1'b1);
        wait_drained();
        // empty slice: zero extent in a used dimension
        cfg_write(CFG_RANK, 64'd2);
        cfg_write(CFG_IN_SHAPE, {16'd9, 16'd9, 16'd9, 16'd9});
        cfg_write(CFG_OUT_SHAPE, {16'd1, 16'd1, 16'd0, 16'd3});
        cfg_write(CFG_BEGIN, {16'd0, 16'd0, 16'd4, 16'd2});
        send_req(1'b0);
        send_req(1'b1);
        wait_drained();
        // zero extent only in unused dimensions
        cfg_write(CFG_RANK, 64'd1);
        for (k = 0; k < 3; k++)
        begin
            send_req(1'b0);
            idle_sender(gap_len());
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        int k;
        cfg_write(CFG_RANK, 64'd2);
        cfg_write(CFG_IN_SHAPE, {16'd1, 16'd1, 16'd10, 16'd10});
        cfg_write(CFG_OUT_SHAPE, {16'd1, 16'd1, 16'd4, 16'd3});
        cfg_write(CFG_BEGIN, {16'd0, 16'd0, 16'd2, 16'd1});
        rx_hold_cycles = 200;
        for (k = 0; k < 80; k++)
            send_req(k == 0);
        wait_drained();
        for (k = 0; k < 20; k++)
        begin
            send_req(1'b0);
            idle_sender(gap_len());
        end
        wait_drained();
    endtask

    task automatic test_random_walks();
        int                  sent;
        int                  n_items;
        int                  r;
        int                  k;
        logic                fast;
        logic                restart_first;
        logic [RANK_BITS-1:0] rk;
        logic [CFG_BITS-1:0] v;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_drained();
            rx_free = 1'b0;
            r  = $urandom_range(19, 0);
            rk = (r == 0) ? 3'd0 :
                 (r == 1) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4, 1));
            if ($urandom_range(9, 0) != 0)
            begin
                v = ($urandom_range(2, 0) == 0) ? {$urandom, $urandom} : 64'd0;
                v[RANK_BITS-1:0] = rk;
                cfg_write(CFG_RANK, v);
            end
            if ($urandom_range(6, 0) != 0)
            begin
                r = $urandom_range(99, 0);
                if (r < 60)
                    v = rand_lanes(1, 4);
                else if (r < 78)
                    v = rand_lanes(1, 12);
                else if (r < 86)
                begin
                    v = rand_lanes(1, 4);
                    v[$urandom_range(3, 0)*DIM_BITS +: DIM_BITS] = '0;
                end
                else if (r < 94)
                    v = {$urandom, $urandom};
                else
                    v = rand_lanes(16'hFFF0, 16'hFFFF);
                cfg_write(CFG_OUT_SHAPE, v);
            end
            r = $urandom_range(3, 0);
            v = (r < 2) ? rand_lanes(1, 20) :
                (r == 2) ? {$urandom, $urandom} : rand_lanes(16'hFF00, 16'hFFFF);
            cfg_write(CFG_IN_SHAPE, v);
            r = $urandom_range(9, 0);
            v = (r < 5) ? rand_lanes(0, 8) :
                (r < 8) ? {$urandom, $urandom} : rand_lanes(16'hFFF0, 16'hFFFF);
            cfg_write(CFG_BEGIN, v);

            fast          = ($urandom_range(4, 0) == 0);
            restart_first = ($urandom_range(9, 0) < 7);
            rx_free       = fast;
            n_items       = $urandom_range(90, 20);
            for (k = 0; k < n_items; k++)
            begin
                send_req((k == 0) ? restart_first : ($urandom_range(19, 0) == 0));
                sent++;
                if (!fast)
                    idle_sender(gap_len());
            end
        end
        wait_drained();
        rx_free = 1'b0;
    endtask

    initial
    begin : main_seq
        int d;
        for (d = 0; d < MAX_DIMS; d++)
            walk_coord[d] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_basic_walk();
        test_extremes();
        test_special_shapes();
        test_backpressure();
        test_random_walks();
        wait_drained();
        repeat (4 * PIPE_LAT) @(posedge clk);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
rtl/nsag_pkg.sv
rtl/nsag_mac_stage.sv
rtl/nd_slice_address_generator.sv
rtl/nsag_checker.sv
dv/testbench.sv
